>>> hw/rtl/bbd_pkg.sv
// Shared types and constants for the binary bitmap downscaler.
`timescale 1ns / 1ps
package bbd_pkg;

  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 11;
  localparam int PCT_W       = 8;
  localparam int TGT_W       = 10;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [PCT_W-1:0] PERCENT_FULL = 8'd100;
  localparam int PCT_FULL_W = $clog2(int'(PERCENT_FULL) + 1);

  localparam logic [CFG_DATA_W-1:0] RST_SRC_WIDTH  = 11'd144;
  localparam logic [CFG_DATA_W-1:0] RST_SRC_HEIGHT = 11'd168;
  localparam logic [PCT_W-1:0]      RST_WIDTH_PCT  = 8'd100;
  localparam logic [PCT_W-1:0]      RST_HEIGHT_PCT = 8'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SRC_WIDTH  = 4'd0,
    CFG_SRC_HEIGHT = 4'd1,
    CFG_WIDTH_PCT  = 4'd2,
    CFG_HEIGHT_PCT = 4'd3
  } cfg_idx_t;

  typedef struct packed {
    logic             pixel_out;
    logic [TGT_W-1:0] target_col;
    logic [TGT_W-1:0] target_row;
    logic             row_end;
    logic             frame_end;
  } res_t;

endpackage

>>> hw/rtl/bbd_if.sv
// Handshake interfaces for the pixel, result and configuration channels.
`timescale 1ns / 1ps
interface pixel_if;
  logic valid;
  logic ready;
  logic pixel_in;
  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

interface result_if import bbd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             pixel_out;
  logic [TGT_W-1:0] target_col;
  logic [TGT_W-1:0] target_row;
  logic             row_end;
  logic             frame_end;
  modport source (output valid, output pixel_out, output target_col, output target_row,
                  output row_end, output frame_end, input ready);
  modport sink (input valid, input pixel_out, input target_col, input target_row,
                input row_end, input frame_end, output ready);
endinterface

interface cfg_if import bbd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/bbd_steps.sv
// Configuration registers and the iterative derivation of target sizes and step terms.
`timescale 1ns / 1ps
module bbd_steps import bbd_pkg::*; #(
  parameter int MAX_DIM = 1024,
  parameter int DIM_W   = 11
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  ready,
  output logic                  enable,
  output logic [DIM_W-1:0]      sw,
  output logic [DIM_W-1:0]      sh,
  output logic [DIM_W-1:0]      tw,
  output logic [DIM_W-1:0]      th,
  output logic [DIM_W-1:0]      col_int,
  output logic [DIM_W-1:0]      col_frac,
  output logic [DIM_W-1:0]      row_int,
  output logic [DIM_W-1:0]      row_frac
);

  localparam int QW    = DIM_W + PCT_W;
  localparam int DVW   = (DIM_W > PCT_FULL_W) ? DIM_W : PCT_FULL_W;
  localparam int CNT_W = $clog2(QW);

  // Reciprocal of the percent base, rounded up. Its error times any dividend below
  // 2**QW stays under 2**RECIP_SH, so the shifted product is the exact floor.
  localparam int RECIP_SH = QW + PCT_FULL_W;
  localparam int RECIP_W  = QW + 1;
  localparam logic [RECIP_W-1:0] RECIP_K =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(PERCENT_FULL) - 64'd1) / 64'(PERCENT_FULL));

  typedef enum logic [1:0] {S_LOAD, S_RUN, S_DONE} state_t;
  typedef enum logic [1:0] {PH_TW, PH_TH, PH_COL, PH_ROW} phase_t;

  state_t                state;
  phase_t                phase;
  logic [CFG_DATA_W-1:0] reg_sw, reg_sh;
  logic [PCT_W-1:0]      reg_wp, reg_hp;
  logic [QW-1:0]         dvd;
  logic [DVW-1:0]        rem, dvs;
  logic [CNT_W-1:0]      cnt;
  logic [DIM_W-1:0]      tw_r, th_r, col_int_r, col_frac_r, row_int_r, row_frac_r;

  logic [DIM_W-1:0] mul_a;
  logic [PCT_W-1:0] mul_pct;
  logic [QW-1:0]    product;
  logic [QW-1:0]    dvd_load;
  logic [DVW-1:0]   dvs_load;
  logic [DVW:0]     rem_sh;
  logic             ge;
  logic [DVW-1:0]   rem_next;
  logic [QW-1:0]    dvd_next;
  logic [QW+RECIP_W-1:0] pct_prod;
  logic [DIM_W-1:0]      pct_quot;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    else if (int'(v) > MAX_DIM) return DIM_W'(MAX_DIM);
    else return DIM_W'(v);
  endfunction

  assign sw = clamp_dim(reg_sw);
  assign sh = clamp_dim(reg_sh);

  assign mul_a    = (phase == PH_TH) ? sh : sw;
  assign mul_pct  = (phase == PH_TH) ? reg_hp : reg_wp;
  assign product  = QW'(mul_a) * QW'(mul_pct);

  // The registered size times percent is divided by the percent base in one step.
  assign pct_prod = (QW+RECIP_W)'(dvd) * (QW+RECIP_W)'(RECIP_K);
  assign pct_quot = pct_prod[RECIP_SH +: DIM_W];

  always_comb begin
    case (phase)
      PH_TW, PH_TH: begin
        dvd_load = product;
        dvs_load = DVW'(PERCENT_FULL);
      end
      PH_COL: begin
        dvd_load = QW'(sw);
        dvs_load = DVW'(tw_r);
      end
      PH_ROW: begin
        dvd_load = QW'(sh);
        dvs_load = DVW'(th_r);
      end
      default: begin
        dvd_load = '0;
        dvs_load = '0;
      end
    endcase
  end

  // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
  assign rem_sh   = {rem, dvd[QW-1]};
  assign ge       = rem_sh >= {1'b0, dvs};
  assign rem_next = ge ? DVW'(rem_sh - {1'b0, dvs}) : DVW'(rem_sh);
  assign dvd_next = {dvd[QW-2:0], ge};

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_LOAD;
      phase  <= PH_TW;
      reg_sw <= RST_SRC_WIDTH;
      reg_sh <= RST_SRC_HEIGHT;
      reg_wp <= RST_WIDTH_PCT;
      reg_hp <= RST_HEIGHT_PCT;
    end else begin
      case (state)
        S_LOAD: begin
          dvd   <= dvd_load;
          dvs   <= dvs_load;
          rem   <= '0;
          cnt   <= CNT_W'(QW - 1);
          state <= S_RUN;
        end
        S_RUN: begin
          dvd <= dvd_next;
          rem <= rem_next;
          cnt <= cnt - CNT_W'(1);
          case (phase)
            PH_TW: begin
              tw_r  <= pct_quot;
              phase <= PH_TH;
              state <= S_LOAD;
            end
            PH_TH: begin
              th_r  <= pct_quot;
              phase <= PH_COL;
              state <= S_LOAD;
            end
            PH_COL: begin
              if (cnt == '0) begin
                col_int_r  <= DIM_W'(dvd_next);
                col_frac_r <= DIM_W'(rem_next);
                phase      <= PH_ROW;
                state      <= S_LOAD;
              end
            end
            PH_ROW: begin
              if (cnt == '0) begin
                row_int_r  <= DIM_W'(dvd_next);
                row_frac_r <= DIM_W'(rem_next);
                state      <= S_DONE;
              end
            end
            default: state <= S_DONE;
          endcase
        end
        S_DONE: state <= S_DONE;
        default: state <= S_LOAD;
      endcase

      // A write restarts the derivation so the next frame sees the new setting.
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_SRC_WIDTH:  reg_sw <= cfg_data;
          CFG_SRC_HEIGHT: reg_sh <= cfg_data;
          CFG_WIDTH_PCT:  reg_wp <= cfg_data[PCT_W-1:0];
          CFG_HEIGHT_PCT: reg_hp <= cfg_data[PCT_W-1:0];
          default: ;
        endcase
        state <= S_LOAD;
        phase <= PH_TW;
      end
    end
  end

  assign ready    = (state == S_DONE);
  assign enable   = (reg_wp <= PERCENT_FULL) && (reg_hp <= PERCENT_FULL) &&
                    (tw_r != '0) && (th_r != '0);
  assign tw       = tw_r;
  assign th       = th_r;
  assign col_int  = col_int_r;
  assign col_frac = col_frac_r;
  assign row_int  = row_int_r;
  assign row_frac = row_frac_r;

  a_write_restarts: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !ready)
    else $error("step terms reported ready right after a register write");

  a_target_fits: assert property (@(posedge clk) disable iff (rst)
    ready && enable |-> (tw <= sw) && (th <= sh))
    else $error("target size exceeds source size");

  a_frac_below_tgt: assert property (@(posedge clk) disable iff (rst)
    ready && enable |-> (col_frac < tw) && (row_frac < th))
    else $error("remainder step not below target size");

endmodule

>>> hw/rtl/bbd_front.sv
// Front end: takes source pixels, walks the source position and picks target pixels.
`timescale 1ns / 1ps
module bbd_front import bbd_pkg::*; #(
  parameter int DIM_W = 11
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             pixel,
  input  logic             steps_ready,
  input  logic             steps_enable,
  input  logic [DIM_W-1:0] steps_sw,
  input  logic [DIM_W-1:0] steps_sh,
  input  logic [DIM_W-1:0] steps_tw,
  input  logic [DIM_W-1:0] steps_th,
  input  logic [DIM_W-1:0] steps_col_int,
  input  logic [DIM_W-1:0] steps_col_frac,
  input  logic [DIM_W-1:0] steps_row_int,
  input  logic [DIM_W-1:0] steps_row_frac,
  input  logic             q_full,
  output logic             push,
  output res_t             item
);

  logic [DIM_W-1:0] src_col, src_row;
  logic [DIM_W:0]   next_sel_col, next_sel_row;
  logic [DIM_W-1:0] col_error, row_error, out_col, out_row;

  logic             lat_enable;
  logic [DIM_W-1:0] lat_sw, lat_sh, lat_tw, lat_th;
  logic [DIM_W-1:0] lat_col_int, lat_col_frac, lat_row_int, lat_row_frac;

  logic             frame_start, accept, row_sel, hit, last_col, last_row;
  logic             eff_enable;
  logic [DIM_W-1:0] eff_sw, eff_sh, eff_tw, eff_th;
  logic [DIM_W-1:0] eff_col_int, eff_col_frac, eff_row_int, eff_row_frac;
  logic [DIM_W:0]   col_sum, row_sum;
  logic             col_wrap, row_wrap;
  logic [DIM_W-1:0] col_error_next, row_error_next;
  logic [DIM_W:0]   next_sel_col_next, next_sel_row_next;

  assign frame_start = (src_col == '0) && (src_row == '0);

  // At a frame start the freshly derived terms apply to this pixel already.
  assign eff_enable   = frame_start ? steps_enable   : lat_enable;
  assign eff_sw       = frame_start ? steps_sw       : lat_sw;
  assign eff_sh       = frame_start ? steps_sh       : lat_sh;
  assign eff_tw       = frame_start ? steps_tw       : lat_tw;
  assign eff_th       = frame_start ? steps_th       : lat_th;
  assign eff_col_int  = frame_start ? steps_col_int  : lat_col_int;
  assign eff_col_frac = frame_start ? steps_col_frac : lat_col_frac;
  assign eff_row_int  = frame_start ? steps_row_int  : lat_row_int;
  assign eff_row_frac = frame_start ? steps_row_frac : lat_row_frac;

  assign in_ready = !q_full && (!frame_start || steps_ready);
  assign accept   = in_valid && in_ready;

  assign row_sel = eff_enable && ({1'b0, src_row} == next_sel_row) && (out_row < eff_th);
  assign hit     = row_sel && ({1'b0, src_col} == next_sel_col) && (out_col < eff_tw);
  assign push    = accept && hit;

  assign item.pixel_out  = pixel;
  assign item.target_col = TGT_W'(out_col);
  assign item.target_row = TGT_W'(out_row);
  assign item.row_end    = (out_col == eff_tw - DIM_W'(1));
  assign item.frame_end  = (out_col == eff_tw - DIM_W'(1)) && (out_row == eff_th - DIM_W'(1));

  assign col_sum           = {1'b0, col_error} + {1'b0, eff_col_frac};
  assign col_wrap          = col_sum >= {1'b0, eff_tw};
  assign col_error_next    = col_wrap ? DIM_W'(col_sum - {1'b0, eff_tw}) : DIM_W'(col_sum);
  assign next_sel_col_next = next_sel_col + {1'b0, eff_col_int} + (DIM_W+1)'(col_wrap);

  assign row_sum           = {1'b0, row_error} + {1'b0, eff_row_frac};
  assign row_wrap          = row_sum >= {1'b0, eff_th};
  assign row_error_next    = row_wrap ? DIM_W'(row_sum - {1'b0, eff_th}) : DIM_W'(row_sum);
  assign next_sel_row_next = next_sel_row + {1'b0, eff_row_int} + (DIM_W+1)'(row_wrap);

  assign last_col = ({1'b0, src_col} + (DIM_W+1)'(1)) >= {1'b0, eff_sw};
  assign last_row = ({1'b0, src_row} + (DIM_W+1)'(1)) >= {1'b0, eff_sh};

  always_ff @(posedge clk) begin
    if (rst) begin
      src_col      <= '0;
      src_row      <= '0;
      next_sel_col <= '0;
      col_error    <= '0;
      out_col      <= '0;
      next_sel_row <= '0;
      row_error    <= '0;
      out_row      <= '0;
    end else if (accept) begin
      if (frame_start) begin
        lat_enable   <= steps_enable;
        lat_sw       <= steps_sw;
        lat_sh       <= steps_sh;
        lat_tw       <= steps_tw;
        lat_th       <= steps_th;
        lat_col_int  <= steps_col_int;
        lat_col_frac <= steps_col_frac;
        lat_row_int  <= steps_row_int;
        lat_row_frac <= steps_row_frac;
      end
      if (hit) begin
        next_sel_col <= next_sel_col_next;
        col_error    <= col_error_next;
        out_col      <= out_col + DIM_W'(1);
      end
      if (!last_col) begin
        src_col <= src_col + DIM_W'(1);
      end else begin
        src_col      <= '0;
        next_sel_col <= '0;
        col_error    <= '0;
        out_col      <= '0;
        if (row_sel) begin
          next_sel_row <= next_sel_row_next;
          row_error    <= row_error_next;
          out_row      <= out_row + DIM_W'(1);
        end
        if (last_row) begin
          src_row      <= '0;
          next_sel_row <= '0;
          row_error    <= '0;
          out_row      <= '0;
        end else begin
          src_row <= src_row + DIM_W'(1);
        end
      end
    end
  end

  a_frame_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && last_col && last_row |=> frame_start)
    else $error("last source pixel did not return to the frame start");

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    !frame_start && lat_enable |-> (out_row <= lat_th) && (out_col <= lat_tw))
    else $error("target position ran past the target size");

endmodule

>>> hw/rtl/bbd_queue.sv
// Back end: short result queue that drives the output channel from registers.
`timescale 1ns / 1ps
module bbd_queue import bbd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_item,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  res_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [PTR_W:0]   count;
  logic             pop;

  assign full      = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign out_valid = (count != '0);
  assign out_item  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + PTR_W'(1);
      case ({push, pop})
        2'b10:   count <= count + (PTR_W+1)'(1);
        2'b01:   count <= count - (PTR_W+1)'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("result pushed into a full queue");

  a_fill_tracks: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + (PTR_W+1)'(1))
    else $error("queue fill count lost a request");

endmodule

>>> hw/rtl/binary_bitmap_downscaler.sv
// A selected pixel is written into the four-entry result queue as it is accepted; the
// queue drives the result channel. Throughput: one source pixel per cycle while the
// queue has room; output stalls fill it and then stall the input. After reset or any
// register write, the step terms are derived anew; only a frame's first pixel waits.
// Reset is synchronous and active high; registers return to 144 x 168 at 100 percent.
`timescale 1ns / 1ps
module binary_bitmap_downscaler import bbd_pkg::*; #(
  parameter int MAX_DIM = 1024
) (
  input  logic     clk,
  input  logic     rst,
  pixel_if.sink    pix_in,
  result_if.source res_out,
  cfg_if.sink      cfg
);

  localparam int DIM_W = $clog2(MAX_DIM + 1);

  logic             steps_ready, steps_enable;
  logic [DIM_W-1:0] steps_sw, steps_sh, steps_tw, steps_th;
  logic [DIM_W-1:0] steps_col_int, steps_col_frac, steps_row_int, steps_row_frac;
  logic             q_full, push;
  res_t             push_item, out_item;

  assign cfg.ready = 1'b1;

  bbd_steps #(
    .MAX_DIM (MAX_DIM),
    .DIM_W   (DIM_W)
  ) u_steps (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .ready     (steps_ready),
    .enable    (steps_enable),
    .sw        (steps_sw),
    .sh        (steps_sh),
    .tw        (steps_tw),
    .th        (steps_th),
    .col_int   (steps_col_int),
    .col_frac  (steps_col_frac),
    .row_int   (steps_row_int),
    .row_frac  (steps_row_frac)
  );

  bbd_front #(
    .DIM_W (DIM_W)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (pix_in.valid),
    .in_ready       (pix_in.ready),
    .pixel          (pix_in.pixel_in),
    .steps_ready    (steps_ready),
    .steps_enable   (steps_enable),
    .steps_sw       (steps_sw),
    .steps_sh       (steps_sh),
    .steps_tw       (steps_tw),
    .steps_th       (steps_th),
    .steps_col_int  (steps_col_int),
    .steps_col_frac (steps_col_frac),
    .steps_row_int  (steps_row_int),
    .steps_row_frac (steps_row_frac),
    .q_full         (q_full),
    .push           (push),
    .item           (push_item)
  );

  bbd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .out_valid (res_out.valid),
    .out_ready (res_out.ready),
    .out_item  (out_item)
  );

  assign res_out.pixel_out  = out_item.pixel_out;
  assign res_out.target_col = out_item.target_col;
  assign res_out.target_row = out_item.target_row;
  assign res_out.row_end    = out_item.row_end;
  assign res_out.frame_end  = out_item.frame_end;

endmodule

>>> test/tb_top.sv
// Self-checking testbench for the binary bitmap downscaler.
`timescale 1ns / 1ps
module tb_top;
  import bbd_pkg::*;

  localparam int MAX_DIM       = 1024;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 10;
  localparam int RANDOM_PIXELS = 600;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 10;

  typedef struct {
    logic [CFG_DATA_W-1:0] sw, sh, tw, th;
    logic [CFG_DATA_W-1:0] col_int, col_frac, row_int, row_frac;
    logic                  enable;
  } scale_steps_t;

  logic clk;
  logic rst;

  pixel_if  pix_bus ();
  result_if res_bus ();
  cfg_if    cfg_bus ();

  binary_bitmap_downscaler #(.MAX_DIM(MAX_DIM)) i_dut (
    .clk     (clk),
    .rst     (rst),
    .pix_in  (pix_bus),
    .res_out (res_bus),
    .cfg     (cfg_bus)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Register copies as written, and the frame walk state of the scaler.
  logic [CFG_DATA_W-1:0] reg_src_width, reg_src_height;
  logic [PCT_W-1:0]      reg_width_pct, reg_height_pct;
  logic [9:0]            src_col, src_row;
  logic [CFG_DATA_W-1:0] next_sel_col, col_error, out_col;
  logic [CFG_DATA_W-1:0] next_sel_row, row_error, out_row;
  scale_steps_t          frame_steps;
  res_t                  expected_pixels[$];

  int failures        = 0;
  int pixels_sent     = 0;
  int results_checked = 0;
  int frames_seen     = 0;
  int reg_writes      = 0;
  int cycle_count     = 0;

  int source_idle_pct   = 25;
  int sink_idle_pct     = 25;
  int sink_hold_request = 0;
  int sink_hold_left    = 0;

  function automatic logic [CFG_DATA_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] v);
    if (v == '0) return CFG_DATA_W'(1);
    if (v > MAX_DIM) return CFG_DATA_W'(MAX_DIM);
    return v;
  endfunction

  function automatic scale_steps_t derive_scale_steps();
    scale_steps_t s;
    int unsigned  tw_full, th_full;
    s.sw = clamp_size(reg_src_width);
    s.sh = clamp_size(reg_src_height);
    s.enable = (reg_width_pct <= PERCENT_FULL) && (reg_height_pct <= PERCENT_FULL);
    tw_full = 0;
    th_full = 0;
    if (s.enable) begin
      tw_full = (int'(s.sw) * int'(reg_width_pct)) / int'(PERCENT_FULL);
      th_full = (int'(s.sh) * int'(reg_height_pct)) / int'(PERCENT_FULL);
    end
    s.tw = tw_full[CFG_DATA_W-1:0];
    s.th = th_full[CFG_DATA_W-1:0];
    if (s.tw == '0 || s.th == '0) s.enable = 1'b0;
    if (s.enable) begin
      s.col_int  = s.sw / s.tw;
      s.col_frac = s.sw % s.tw;
      s.row_int  = s.sh / s.th;
      s.row_frac = s.sh % s.th;
    end else begin
      s.col_int  = '0;
      s.col_frac = '0;
      s.row_int  = '0;
      s.row_frac = '0;
    end
    return s;
  endfunction

  // Advances the walk by one source pixel and queues the target pixel it selects, if any.
  function automatic void predict_scaled_pixel(input logic pix);
    res_t r;
    logic row_sel;
    if (src_col == '0 && src_row == '0) begin
      frame_steps  = derive_scale_steps();
      next_sel_col = '0;
      col_error    = '0;
      out_col      = '0;
      next_sel_row = '0;
      row_error    = '0;
      out_row      = '0;
    end
    row_sel = frame_steps.enable && ({1'b0, src_row} == next_sel_row) &&
              (out_row < frame_steps.th);
    if (row_sel && {1'b0, src_col} == next_sel_col && out_col < frame_steps.tw) begin
      r.pixel_out  = pix;
      r.target_col = out_col[TGT_W-1:0];
      r.target_row = out_row[TGT_W-1:0];
      r.row_end    = (out_col == frame_steps.tw - 1'b1);
      r.frame_end  = r.row_end && (out_row == frame_steps.th - 1'b1);
      expected_pixels.push_back(r);
      next_sel_col += frame_steps.col_int;
      col_error    += frame_steps.col_frac;
      if (col_error >= frame_steps.tw) begin
        col_error -= frame_steps.tw;
        next_sel_col++;
      end
      out_col++;
    end
    if ({1'b0, src_col} + 1'b1 >= frame_steps.sw) begin
      src_col      = '0;
      next_sel_col = '0;
      col_error    = '0;
      out_col      = '0;
      if (row_sel) begin
        next_sel_row += frame_steps.row_int;
        row_error    += frame_steps.row_frac;
        if (row_error >= frame_steps.th) begin
          row_error -= frame_steps.th;
          next_sel_row++;
        end
        out_row++;
      end
      if ({1'b0, src_row} + 1'b1 >= frame_steps.sh) begin
        src_row      = '0;
        next_sel_row = '0;
        row_error    = '0;
        out_row      = '0;
      end else begin
        src_row++;
      end
    end else begin
      src_col++;
    end
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("[%0t] %s", $time, msg);
  endfunction

  // One process sees every handshake of a cycle, so prediction and checking keep their order.
  always @(posedge clk) begin
    res_t got, want;
    if (rst) begin
      reg_src_width  = RST_SRC_WIDTH;
      reg_src_height = RST_SRC_HEIGHT;
      reg_width_pct  = RST_WIDTH_PCT;
      reg_height_pct = RST_HEIGHT_PCT;
      src_col        = '0;
      src_row        = '0;
      next_sel_col   = '0;
      col_error      = '0;
      out_col        = '0;
      next_sel_row   = '0;
      row_error      = '0;
      out_row        = '0;
      frame_steps    = derive_scale_steps();
      expected_pixels.delete();
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        case (cfg_idx_t'(cfg_bus.index))
          CFG_SRC_WIDTH:  reg_src_width  = cfg_bus.data;
          CFG_SRC_HEIGHT: reg_src_height = cfg_bus.data;
          CFG_WIDTH_PCT:  reg_width_pct  = cfg_bus.data[PCT_W-1:0];
          CFG_HEIGHT_PCT: reg_height_pct = cfg_bus.data[PCT_W-1:0];
          default: ;
        endcase
      end
      if (pix_bus.valid && pix_bus.ready) predict_scaled_pixel(pix_bus.pixel_in);
      if (res_bus.valid && res_bus.ready) begin
        got.pixel_out  = res_bus.pixel_out;
        got.target_col = res_bus.target_col;
        got.target_row = res_bus.target_row;
        got.row_end    = res_bus.row_end;
        got.frame_end  = res_bus.frame_end;
        if (expected_pixels.size() == 0) begin
          note_failure($sformatf("unexpected pixel=%0d col=%0d row=%0d row_end=%0d frame_end=%0d",
                                 got.pixel_out, got.target_col, got.target_row,
                                 got.row_end, got.frame_end));
        end else begin
          want = expected_pixels.pop_front();
          results_checked++;
          if (got.pixel_out !== want.pixel_out || got.target_col !== want.target_col ||
              got.target_row !== want.target_row || got.row_end !== want.row_end ||
              got.frame_end !== want.frame_end) begin
            note_failure($sformatf({"mismatch expected pixel=%0d col=%0d row=%0d re=%0d fe=%0d",
                                    ", got pixel=%0d col=%0d row=%0d re=%0d fe=%0d"},
                                   want.pixel_out, want.target_col, want.target_row,
                                   want.row_end, want.frame_end,
                                   got.pixel_out, got.target_col, got.target_row,
                                   got.row_end, got.frame_end));
          end
          if (got.frame_end) frames_seen++;
        end
      end
    end
  end

  // Result receiver: random stalls, or a long hold-off when a test asks for one.
  initial begin
    res_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_hold_request > 0) begin
        sink_hold_left    = sink_hold_request;
        sink_hold_request = 0;
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        res_bus.ready <= 1'b0;
      end else begin
        res_bus.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected",
               cycle_count, expected_pixels.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Leaves valid high after acceptance so back-to-back pixels need no extra edge.
  task automatic send_pixel(input logic pix);
    if (source_idle_pct > 0 && $urandom_range(99) < source_idle_pct) begin
      pix_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pix_bus.valid    <= 1'b1;
    pix_bus.pixel_in <= pix;
    do @(posedge clk); while (!pix_bus.ready);
    pixels_sent++;
  endtask

  task automatic send_random_pixels(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) send_pixel($urandom_range(1));
  endtask

  // Stops the pixel requests and waits until every expected result has arrived.
  task automatic wait_for_results();
    pix_bus.valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    cfg_bus.index <= idx;
    cfg_bus.data  <= value;
    cfg_bus.valid <= 1'b1;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    @(posedge clk);
    reg_writes++;
  endtask

  task automatic write_config(input logic [CFG_DATA_W-1:0] sw, input logic [CFG_DATA_W-1:0] sh,
                              input logic [PCT_W-1:0] wp, input logic [PCT_W-1:0] hp);
    wait_for_results();
    write_register(CFG_SRC_WIDTH, sw);
    write_register(CFG_SRC_HEIGHT, sh);
    write_register(CFG_WIDTH_PCT, CFG_DATA_W'(wp));
    write_register(CFG_HEIGHT_PCT, CFG_DATA_W'(hp));
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_size(input int unsigned common_max);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 5) return '0;
    if (r < 85) return CFG_DATA_W'($urandom_range(1, common_max));
    return CFG_DATA_W'($urandom_range(common_max + 1, 4 * common_max));
  endfunction

  function automatic logic [PCT_W-1:0] pick_percent();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return PCT_W'($urandom_range(1, 100));
    if (r < 70) return PERCENT_FULL;
    if (r < 80) return PCT_W'($urandom_range(0, 20));
    if (r < 92) return PCT_W'($urandom_range(101, 255));
    return '0;
  endfunction

  // Small frames with uneven ratios so both error terms carry.
  task automatic test_directed_scaling();
    write_config(11'd5, 11'd2, 8'd60, 8'd50);
    for (int i = 0; i < 10; i++) send_pixel(i[0] ^ i[2]);
    write_config(11'd4, 11'd3, 8'd50, 8'd67);
    for (int i = 0; i < 12; i++) send_pixel(^i[1:0]);
    wait_for_results();
  endtask

  // Percent above full scale, or a target size that floors to zero, must emit nothing.
  task automatic test_disabled_output();
    write_config(11'd2, 11'd2, 8'd101, 8'd100);
    send_random_pixels(4);
    write_config(11'd2, 11'd2, 8'd100, 8'd255);
    send_random_pixels(4);
    write_config(11'd3, 11'd2, 8'd30, 8'd100);
    send_random_pixels(6);
    write_config(11'd2, 11'd2, 8'd100, 8'd0);
    send_random_pixels(4);
    write_config(11'd2, 11'd2, 8'd100, 8'd100);
    send_random_pixels(4);
    wait_for_results();
  endtask

  // Zero sizes count as one and an oversized width as the maximum dimension.
  task automatic test_size_clamping();
    write_config(11'd0, 11'd0, 8'd100, 8'd100);
    send_random_pixels(2);
    write_config(11'd2047, 11'd0, 8'd1, 8'd100);
    send_random_pixels(MAX_DIM);
    wait_for_results();
  endtask

  // A write in the middle of a frame only applies from the next frame start.
  task automatic test_midframe_config();
    write_config(11'd4, 11'd3, 8'd50, 8'd100);
    send_random_pixels(5);
    write_config(11'd3, 11'd2, 8'd100, 8'd100);
    send_random_pixels(7);
    send_random_pixels(6);
    wait_for_results();
  endtask

  // The receiver holds off long enough to fill the result queue and stall the input;
  // halfway through the frame the sender pauses until everything has drained.
  task automatic test_backpressure();
    write_config(11'd16, 11'd8, 8'd100, 8'd100);
    source_idle_pct   = 0;
    sink_hold_request = 300;
    send_random_pixels(64);
    wait_for_results();
    send_random_pixels(64);
    source_idle_pct = 25;
    wait_for_results();
  endtask

  task automatic test_random_frames();
    logic [CFG_DATA_W-1:0] sw, sh, value;
    logic [PCT_W-1:0]      wp, hp;
    cfg_idx_t              idx;
    int unsigned           sent_here, count;
    int                    round;
    sent_here = 0;
    round     = 0;
    sw = pick_size(12);
    sh = pick_size(8);
    wp = pick_percent();
    hp = pick_percent();
    write_config(sw, sh, wp, hp);
    while (sent_here < RANDOM_PIXELS) begin
      // A run of rounds with neither side idling.
      source_idle_pct = (round >= 4 && round < 12) ? 0 : 25;
      sink_idle_pct   = source_idle_pct;
      if ($urandom_range(99) < 80) begin
        sw = pick_size(12);
        sh = pick_size(8);
        wp = pick_percent();
        hp = pick_percent();
        write_config(sw, sh, wp, hp);
      end else begin
        idx = cfg_idx_t'($urandom_range(int'(CFG_HEIGHT_PCT)));
        case (idx)
          CFG_SRC_WIDTH: begin
            sw    = pick_size(12);
            value = sw;
          end
          CFG_SRC_HEIGHT: begin
            sh    = pick_size(8);
            value = sh;
          end
          CFG_WIDTH_PCT: begin
            wp    = pick_percent();
            value = CFG_DATA_W'(wp);
          end
          default: begin
            hp    = pick_percent();
            value = CFG_DATA_W'(hp);
          end
        endcase
        wait_for_results();
        write_register(idx, value);
      end
      count = $urandom_range(1, 3) * clamp_size(sw) * clamp_size(sh);
      // A ragged count leaves a frame open, so the next write lands mid-frame.
      if ($urandom_range(99) < 10) count += $urandom_range(1, 7);
      if (count > RANDOM_PIXELS - sent_here) count = RANDOM_PIXELS - sent_here;
      send_random_pixels(count);
      sent_here += count;
      round++;
    end
    source_idle_pct = 25;
    sink_idle_pct   = 25;
    wait_for_results();
  endtask

  initial begin
    rst              <= 1'b1;
    pix_bus.valid    <= 1'b0;
    pix_bus.pixel_in <= 1'b0;
    cfg_bus.valid    <= 1'b0;
    cfg_bus.index    <= CFG_SRC_WIDTH;
    cfg_bus.data     <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_directed_scaling();
    test_disabled_output();
    test_size_clamping();
    test_midframe_config();
    test_backpressure();
    test_random_frames();

    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (expected_pixels.size() != 0) begin
      note_failure($sformatf("%0d expected results never arrived", expected_pixels.size()));
    end
    $display("Covered error-term stepping, disabled output, size clamping, mid-frame writes,");
    $display("  backpressure and random frames: %0d pixels, %0d results, %0d frames, %0d writes",
             pixels_sent, results_checked, frames_seen, reg_writes);
    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d failures", failures);
      $display("simulation failed");
    end
    $finish;
  end

endmodule
